[rtl/core/assert_macros.svh]
// Assertion macros shared by the frame CRC signature unit.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FCRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/fcrc_pkg.sv]
// Shared types, constants and the CRC byte function of the frame CRC unit.
// No dependencies; imported by every module of the block.
package fcrc_pkg;

  localparam int PIXEL_BITS      = 16;
  localparam int BYTES_PER_PIXEL = PIXEL_BITS / 8;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 512;
  localparam int QUEUE_DEPTH     = 4;

  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 10;
  localparam int PITCH_W  = 12;
  localparam int COUNT_W  = 21;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 2'd2;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [9:0]  HEIGHT_RESET = 10'd400;
  localparam logic [11:0] PITCH_RESET  = 12'd1280;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [1:0] KIND_VIS  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data;
    logic [COUNT_W-1:0] count;
  } fcrc_entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/core/fcrc_front.sv]
// Front end: accepts surface bytes, tracks row and column, and classifies
// each byte as visible, frame end, geometry error or padding. Uses fcrc_pkg.
module fcrc_front
  import fcrc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [WIDTH_W-1:0]  frame_width,
  input  logic [HEIGHT_W-1:0] frame_height,
  input  logic [PITCH_W-1:0]  row_pitch,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_mem_byte,
  input  logic                q_full,
  output logic                q_push,
  output fcrc_entry_t         q_entry
);

  logic [PITCH_W-1:0]  col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [PITCH_W-1:0]  line_bytes;
  logic [PITCH_W:0]    col_inc;
  logic [21:0]         vis_prod;
  logic                geom_err, visible, last_row, done, wrap, accept;

  assign in_stall   = q_full;
  assign accept     = in_valid && !in_stall;
  assign line_bytes = PITCH_W'(frame_width * BYTES_PER_PIXEL);
  assign col_inc    = {1'b0, col_r} + 13'd1;
  assign vis_prod   = 22'(line_bytes) * 22'(frame_height);

  assign geom_err = (frame_width == '0) || (int'(frame_width) > MAX_WIDTH) ||
                    (frame_height == '0) || (int'(frame_height) > MAX_HEIGHT) ||
                    (row_pitch < line_bytes);
  assign visible  = col_r < line_bytes;
  assign last_row = ({1'b0, row_r} + 11'd1) >= {1'b0, frame_height};
  assign done     = visible && (col_inc == {1'b0, line_bytes}) && last_row;
  assign wrap     = col_inc >= {1'b0, row_pitch};

  assign q_push = accept && (geom_err || visible);

  always_comb begin
    q_entry.data  = in_mem_byte;
    q_entry.count = vis_prod[COUNT_W-1:0];
    if (geom_err) begin
      q_entry.kind = KIND_ERR;
    end else if (done) begin
      q_entry.kind = KIND_DONE;
    end else begin
      q_entry.kind = KIND_VIS;
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && !geom_err) begin
      if (done) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (wrap) begin
        col_nxt = '0;
        row_nxt = row_r + 10'd1;
      end else begin
        col_nxt = col_inc[PITCH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

`include "assert_macros.svh"
  `FCRC_ASSERT_NEXT(a_done_clears, q_push && done && !geom_err, !(|{col_r, row_r}), "counters kept")
  `FCRC_ASSERT_NEXT(a_err_holds, accept && geom_err, $stable({col_r, row_r}), "counters moved")

endmodule

[rtl/core/fcrc_queue.sv]
// Short FIFO of classified bytes between the front and back ends.
// Uses fcrc_pkg for the entry type and depth.
module fcrc_queue
  import fcrc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  fcrc_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output fcrc_entry_t head_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  fcrc_entry_t        slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

`include "assert_macros.svh"
  `FCRC_ASSERT(a_count_range, count_r <= CNT_W'(DEPTH), "queue count above depth")
  `FCRC_ASSERT(a_no_overflow, !(push && full), "push into a full queue")

endmodule

[rtl/core/fcrc_back.sv]
// Back end: runs the CRC over visible bytes and holds the result register.
// Uses fcrc_pkg for the entry type, kinds and crc_byte.
module fcrc_back
  import fcrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  fcrc_entry_t        head_entry,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_crc_value,
  output logic [COUNT_W-1:0] out_visible_count,
  output logic               out_status
);

  logic [31:0]        crc_r, crc_nxt, crc_upd;
  logic               out_valid_r;
  logic [31:0]        out_crc_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_status_r;
  logic               out_free, is_vis, is_done, pop_result;

  assign out_free   = !out_valid_r || !out_stall;
  assign is_vis     = head_entry.kind == KIND_VIS;
  assign is_done    = head_entry.kind == KIND_DONE;
  assign pop        = head_valid && (is_vis || out_free);
  assign pop_result = pop && !is_vis;
  assign crc_upd    = crc_byte(crc_r, head_entry.data);

  always_comb begin
    crc_nxt = crc_r;
    if (pop && is_vis) begin
      crc_nxt = crc_upd;
    end else if (pop && is_done) begin
      crc_nxt = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      crc_r <= crc_nxt;
      if (out_free) begin
        out_valid_r <= pop_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_result) begin
      if (is_done) begin
        out_crc_r    <= ~crc_upd;
        out_count_r  <= head_entry.count;
        out_status_r <= 1'b0;
      end else begin
        out_crc_r    <= '0;
        out_count_r  <= '0;
        out_status_r <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_crc_value     = out_crc_r;
  assign out_visible_count = out_count_r;
  assign out_status        = out_status_r;

`include "assert_macros.svh"
  `FCRC_ASSERT_NEXT(a_crc_restart, pop && is_done, crc_r == CRC_INIT, "CRC not restarted after frame end")
  `FCRC_ASSERT(a_err_zero, !(out_valid_r && out_status_r) || ((out_crc_r == '0) && (out_count_r == '0)), "error result has nonzero fields")

endmodule

[rtl/core/frame_crc32_signature_unit.sv]
// Frame CRC-32 signature unit: top level with configuration registers.
// Instantiates fcrc_front, fcrc_queue and fcrc_back; uses fcrc_pkg.
//
// The unit takes one surface byte per cycle while in_stall is low and computes
// the CRC-32 (ISO-HDLC) of the visible 2*frame_width bytes of each row over
// frame_height rows, with padding bytes skipped. A result is registered when
// the last visible byte of the frame leaves the queue, or after each byte when
// geometry is unsupported. The sustained rate is one byte per cycle, set by
// the single-byte CRC update in the back end; a four-entry queue lets input
// continue while a result waits. Write configuration only while the unit is idle.
module frame_crc32_signature_unit
  import fcrc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PITCH_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_mem_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_crc_value,
  output logic [COUNT_W-1:0]   out_visible_count,
  output logic                 out_status
);

  logic [WIDTH_W-1:0]  frame_width_r;
  logic [HEIGHT_W-1:0] frame_height_r;
  logic [PITCH_W-1:0]  row_pitch_r;
  logic                q_full, q_push, q_pop, q_head_valid;
  fcrc_entry_t         q_entry, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
      row_pitch_r    <= PITCH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[HEIGHT_W-1:0];
        REG_ROW_PITCH:    row_pitch_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  fcrc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .row_pitch    (row_pitch_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mem_byte  (in_mem_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  fcrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head)
  );

  fcrc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_head_valid),
    .head_entry        (q_head),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_crc_value     (out_crc_value),
    .out_visible_count (out_visible_count),
    .out_status        (out_status)
  );

endmodule
